// File: hdl/cdcs_pkg.sv
// Shared types and constants for the command driven character stack.
package cdcs_pkg;

  localparam int CMD_W  = 4;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 6;
  localparam int ST_W   = 3;

  // Command codes as they arrive on the command port
  localparam logic [CMD_W-1:0] CMD_PUSH    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LIST    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_FULL    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_COUNT   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_TOP     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_MEMBER  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_EMPTY   = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SWAP    = 4'd11;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 4'd12;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_ROOM  = 3'd2;
  localparam logic [ST_W-1:0] ST_POP_BIG  = 3'd3;
  localparam logic [ST_W-1:0] ST_SWAP_FEW = 3'd4;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = 1;

  typedef enum logic [3:0] {
    OP_PUSH,
    OP_LIST,
    OP_PEEK,
    OP_POP,
    OP_FULL,
    OP_COUNT,
    OP_TOP,
    OP_MEMBER,
    OP_REPLACE,
    OP_CLEAR,
    OP_EMPTY,
    OP_SWAP,
    OP_REVERSE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data_char;
    logic [CNT_W-1:0]  pop_count;
    logic              group_start;
    logic [CNT_W-1:0]  group_length;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] char_out;
    logic [CNT_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
    logic              answer_flag;
    logic              last;
  } res_t;

endpackage

// File: hdl/cdcs_front.sv
// Front end: accepts command items, decodes them and hands them to the queue.
module cdcs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [cdcs_pkg::CMD_W-1:0]   command,
  input  logic [cdcs_pkg::DATA_W-1:0]  data_char,
  input  logic [cdcs_pkg::CNT_W-1:0]   pop_count,
  input  logic                         group_start,
  input  logic [cdcs_pkg::CNT_W-1:0]   group_length,
  input  logic                         q_full,
  output logic                         q_push,
  output cdcs_pkg::item_t              q_item
);

  logic            held;
  cdcs_pkg::item_t item;
  cdcs_pkg::op_t   op_dec;
  logic            take;

  assign busy   = held & q_full;
  assign take   = start & ~busy;
  assign q_push = held;
  assign q_item = item;

  always_comb begin
    unique case (command)
      cdcs_pkg::CMD_PUSH:    op_dec = cdcs_pkg::OP_PUSH;
      cdcs_pkg::CMD_LIST:    op_dec = cdcs_pkg::OP_LIST;
      cdcs_pkg::CMD_PEEK:    op_dec = cdcs_pkg::OP_PEEK;
      cdcs_pkg::CMD_POP:     op_dec = cdcs_pkg::OP_POP;
      cdcs_pkg::CMD_FULL:    op_dec = cdcs_pkg::OP_FULL;
      cdcs_pkg::CMD_COUNT:   op_dec = cdcs_pkg::OP_COUNT;
      cdcs_pkg::CMD_TOP:     op_dec = cdcs_pkg::OP_TOP;
      cdcs_pkg::CMD_MEMBER:  op_dec = cdcs_pkg::OP_MEMBER;
      cdcs_pkg::CMD_REPLACE: op_dec = cdcs_pkg::OP_REPLACE;
      cdcs_pkg::CMD_CLEAR:   op_dec = cdcs_pkg::OP_CLEAR;
      cdcs_pkg::CMD_EMPTY:   op_dec = cdcs_pkg::OP_EMPTY;
      cdcs_pkg::CMD_SWAP:    op_dec = cdcs_pkg::OP_SWAP;
      cdcs_pkg::CMD_REVERSE: op_dec = cdcs_pkg::OP_REVERSE;
      default:               op_dec = cdcs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (held && !q_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.op           <= op_dec;
      item.data_char    <= data_char;
      item.pop_count    <= pop_count;
      item.group_start  <= group_start;
      item.group_length <= group_length;
    end
  end

endmodule

// File: hdl/cdcs_queue.sv
// Short command queue that decouples the front end from the execution back end.
module cdcs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cdcs_pkg::item_t wr_item,
  input  logic            pop,
  output cdcs_pkg::item_t rd_item,
  output logic            valid,
  output logic            full
);

  cdcs_pkg::item_t                slots [cdcs_pkg::QUEUE_DEPTH];
  logic [cdcs_pkg::Q_AW-1:0]      wr_ptr;
  logic [cdcs_pkg::Q_AW-1:0]      rd_ptr;
  logic [cdcs_pkg::Q_AW:0]        count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = count == (cdcs_pkg::Q_AW + 1)'(cdcs_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == cdcs_pkg::Q_AW'(cdcs_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + cdcs_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == cdcs_pkg::Q_AW'(cdcs_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + cdcs_pkg::Q_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (cdcs_pkg::Q_AW + 1)'(1);
        2'b01:   count <= count - (cdcs_pkg::Q_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: hdl/cdcs_back.sv
// Back end: owns the stack memory and size, executes commands and walks entries.
module cdcs_back #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  cdcs_pkg::item_t q_item,
  output logic            q_pop,
  output logic            res_valid,
  output cdcs_pkg::res_t  res
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = ((SW > cdcs_pkg::CNT_W) ? SW : cdcs_pkg::CNT_W) + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_PRIME  = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_SWAP_A = 7'b0010000,
    S_SWAP_B = 7'b0100000,
    S_SWAP_C = 7'b1000000
  } state_t;

  state_t                         state;
  cdcs_pkg::item_t                cur;
  logic [SW-1:0]                  stack_size;
  logic                           drop_group;
  logic [AW-1:0]                  walk_idx;
  logic [SW-1:0]                  walk_left;
  logic                           walk_down;
  logic                           walk_search;
  logic [cdcs_pkg::CNT_W-1:0]     walk_pos;
  logic [cdcs_pkg::CNT_W-1:0]     walk_cnt;
  logic                           found;
  logic [cdcs_pkg::DATA_W-1:0]    swap_tmp;

  logic [cdcs_pkg::DATA_W-1:0]    mem [DEPTH];
  logic [cdcs_pkg::DATA_W-1:0]    rd_data;
  logic [AW-1:0]                  rd_addr;
  logic                           we;
  logic [AW-1:0]                  wr_addr;
  logic [cdcs_pkg::DATA_W-1:0]    wr_data;

  logic [AW-1:0]                  top_addr;
  logic [AW-1:0]                  below_addr;
  logic [AW-1:0]                  walk_step;
  logic [CW-1:0]                  size_w;
  logic [CW-1:0]                  free_w;
  logic [CW-1:0]                  pop_n_w;
  logic [SW-1:0]                  pop_rest;
  logic [cdcs_pkg::CNT_W-1:0]     size_c;
  logic                           size_zero;
  logic                           is_full;
  logic                           match;
  logic                           walk_end;
  logic                           push_wr;
  logic                           push_drop;
  logic [cdcs_pkg::ST_W-1:0]      push_st;

  function automatic cdcs_pkg::res_t mk_res(
    input logic [cdcs_pkg::ST_W-1:0]   st,
    input logic [cdcs_pkg::DATA_W-1:0] ch,
    input logic [cdcs_pkg::CNT_W-1:0]  pos,
    input logic [cdcs_pkg::CNT_W-1:0]  cnt,
    input logic                        flag,
    input logic                        lst
  );
    cdcs_pkg::res_t r;
    r.status      = st;
    r.char_out    = ch;
    r.position    = pos;
    r.entry_count = cnt;
    r.answer_flag = flag;
    r.last        = lst;
    return r;
  endfunction

  assign top_addr   = AW'(stack_size - SW'(1));
  assign below_addr = AW'(stack_size - SW'(2));
  assign walk_step  = walk_down ? walk_idx - AW'(1) : walk_idx + AW'(1);
  assign size_w     = CW'(stack_size);
  assign free_w     = CW'(DEPTH) - size_w;
  assign pop_n_w    = (cur.pop_count == '0) ? CW'(1) : CW'(cur.pop_count);
  assign pop_rest   = stack_size - SW'(pop_n_w);
  assign size_c     = cdcs_pkg::CNT_W'(stack_size);
  assign size_zero  = stack_size == '0;
  assign is_full    = size_w >= CW'(DEPTH);
  assign match      = rd_data == cur.data_char;
  assign walk_end   = walk_left == SW'(1);
  assign q_pop      = (state == S_IDLE) && q_valid;

  // Push group decision: start item checks the room, later items follow the drop flag and else check for a full stack
  always_comb begin
    push_wr   = 1'b0;
    push_drop = drop_group;
    push_st   = cdcs_pkg::ST_OK;
    if (cur.group_start) begin
      if (CW'(cur.group_length) > free_w) begin
        push_drop = 1'b1;
        push_st   = cdcs_pkg::ST_NO_ROOM;
      end else if (cur.group_length == '0) begin
        push_drop = 1'b1;
      end else begin
        push_drop = 1'b0;
        push_wr   = 1'b1;
      end
    end else if (drop_group) begin
      push_st = cdcs_pkg::ST_NO_ROOM;
    end else if (is_full) begin
      push_drop = 1'b1;
      push_st   = cdcs_pkg::ST_NO_ROOM;
    end else begin
      push_wr = 1'b1;
    end
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = top_addr;
    wr_data = cur.data_char;
    case (state)
      S_DECIDE: begin
        if (cur.op == cdcs_pkg::OP_PUSH && push_wr) begin
          we      = 1'b1;
          wr_addr = AW'(stack_size);
        end else if (cur.op == cdcs_pkg::OP_REPLACE && !size_zero) begin
          we = 1'b1;
        end
      end
      S_SWAP_B: begin
        we      = 1'b1;
        wr_data = rd_data;
      end
      S_SWAP_C: begin
        we      = 1'b1;
        wr_addr = below_addr;
        wr_data = swap_tmp;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    case (state)
      S_DECIDE: rd_addr = top_addr;
      S_SWAP_A: rd_addr = below_addr;
      default:  rd_addr = walk_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stack_size <= '0;
      drop_group <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          state       <= S_IDLE;
          drop_group  <= 1'b0;
          found       <= 1'b0;
          walk_search <= 1'b0;
          walk_pos    <= '0;
          walk_cnt    <= size_c;
          walk_left   <= stack_size;
          walk_idx    <= '0;
          walk_down   <= 1'b0;
          unique case (cur.op) inside
            cdcs_pkg::OP_PUSH: begin
              drop_group <= push_drop;
              res_valid  <= 1'b1;
              if (push_wr) begin
                stack_size <= stack_size + SW'(1);
                res <= mk_res(push_st, '0, '0, cdcs_pkg::CNT_W'(stack_size + SW'(1)),
                              1'b0, 1'b1);
              end else begin
                res <= mk_res(push_st, '0, '0, size_c, 1'b0, 1'b1);
              end
            end
            cdcs_pkg::OP_LIST, cdcs_pkg::OP_REVERSE: begin
              if (size_zero) begin
                res_valid <= 1'b1;
                res       <= mk_res(cdcs_pkg::ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
              end else begin
                walk_down <= cur.op == cdcs_pkg::OP_REVERSE;
                walk_idx  <= (cur.op == cdcs_pkg::OP_REVERSE) ? top_addr : '0;
                state     <= S_PRIME;
              end
            end
            cdcs_pkg::OP_PEEK, cdcs_pkg::OP_TOP: begin
              if (size_zero) begin
                res_valid <= 1'b1;
                res       <= mk_res(cdcs_pkg::ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
              end else begin
                walk_idx  <= top_addr;
                walk_left <= SW'(1);
                walk_pos  <= (cur.op == cdcs_pkg::OP_TOP) ? size_c : '0;
                state     <= S_PRIME;
              end
            end
            cdcs_pkg::OP_POP: begin
              if (cur.pop_count == '0 && size_zero) begin
                res_valid <= 1'b1;
                res       <= mk_res(cdcs_pkg::ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
              end else if (pop_n_w > size_w) begin
                res_valid <= 1'b1;
                res       <= mk_res(cdcs_pkg::ST_POP_BIG, '0, '0, size_c, 1'b0, 1'b1);
              end else begin
                // Entries stay in memory; the walk reads them top down
                stack_size <= pop_rest;
                walk_cnt   <= cdcs_pkg::CNT_W'(pop_rest);
                walk_left  <= SW'(pop_n_w);
                walk_idx   <= top_addr;
                walk_down  <= 1'b1;
                state      <= S_PRIME;
              end
            end
            cdcs_pkg::OP_CLEAR: begin
              if (size_zero) begin
                res_valid <= 1'b1;
                res       <= mk_res(cdcs_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b1);
              end else begin
                stack_size <= '0;
                walk_cnt   <= '0;
                walk_idx   <= top_addr;
                walk_down  <= 1'b1;
                state      <= S_PRIME;
              end
            end
            cdcs_pkg::OP_MEMBER: begin
              if (size_zero) begin
                res_valid <= 1'b1;
                res       <= mk_res(cdcs_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b1);
              end else begin
                walk_search <= 1'b1;
                state       <= S_PRIME;
              end
            end
            cdcs_pkg::OP_REPLACE: begin
              res_valid <= 1'b1;
              if (size_zero) begin
                res <= mk_res(cdcs_pkg::ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
              end else begin
                res <= mk_res(cdcs_pkg::ST_OK, '0, '0, size_c, 1'b0, 1'b1);
              end
            end
            cdcs_pkg::OP_SWAP: begin
              if (stack_size < SW'(2)) begin
                res_valid <= 1'b1;
                res       <= mk_res(cdcs_pkg::ST_SWAP_FEW, '0, '0, size_c, 1'b0, 1'b1);
              end else begin
                state <= S_SWAP_A;
              end
            end
            cdcs_pkg::OP_FULL: begin
              res_valid <= 1'b1;
              res       <= mk_res(cdcs_pkg::ST_OK, '0, '0, size_c, is_full, 1'b1);
            end
            cdcs_pkg::OP_EMPTY: begin
              res_valid <= 1'b1;
              res       <= mk_res(cdcs_pkg::ST_OK, '0, '0, size_c, size_zero, 1'b1);
            end
            default: begin
              res_valid <= 1'b1;
              res       <= mk_res(cdcs_pkg::ST_OK, '0, '0, size_c, 1'b0, 1'b1);
            end
          endcase
        end

        S_PRIME: begin
          if (!walk_end) begin
            walk_idx <= walk_step;
          end
          state <= S_WALK;
        end

        S_WALK: begin
          if (walk_search) begin
            found <= found | match;
            if (walk_end) begin
              res_valid <= 1'b1;
              res <= mk_res(cdcs_pkg::ST_OK, '0, '0, walk_cnt, found | match, 1'b1);
            end
          end else begin
            res_valid <= 1'b1;
            res <= mk_res(cdcs_pkg::ST_OK, rd_data, walk_pos, walk_cnt, 1'b0, walk_end);
          end
          if (walk_end) begin
            state <= S_IDLE;
          end else begin
            walk_left <= walk_left - SW'(1);
            if (walk_left != SW'(2)) begin
              walk_idx <= walk_step;
            end
          end
        end

        S_SWAP_A: begin
          swap_tmp <= rd_data;
          state    <= S_SWAP_B;
        end

        S_SWAP_B: begin
          state <= S_SWAP_C;
        end

        S_SWAP_C: begin
          // Swap done; list the whole stack bottom to top
          walk_idx  <= '0;
          walk_down <= 1'b0;
          walk_left <= stack_size;
          walk_cnt  <= size_c;
          walk_pos  <= '0;
          state     <= S_PRIME;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/command_driven_char_stack_top.sv
// Command driven character stack: a byte LIFO of DEPTH entries with search and listing.
//
// Input channel: an item (command and its operands) is taken at a rising edge
// where start is high and busy is low. busy rises only when the front register
// and the two-entry command queue are both occupied.
// Result channel: each result is shown for exactly one cycle with strobe high;
// the receiver cannot stall it. last marks the final result of an item.
// The first result of an item passes the front register, the queue, the fetch
// into the back end and the execute step.
// Throughput: the back end takes a new item only after the last one is done. Listing,
// pop, clear and member walk the stack memory through its one registered read
// port: a prime step, then one entry per cycle. Swap adds three read-modify-write
// steps on the memory before its listing.
// Reset: rst (synchronous) empties the stack, clears the push-group drop flag
// and flushes the queue; memory contents are not cleared, and only written
// entries ever reach a result.
module command_driven_char_stack_top #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [cdcs_pkg::CMD_W-1:0]   command,
  input  logic [cdcs_pkg::DATA_W-1:0]  data_char,
  input  logic [cdcs_pkg::CNT_W-1:0]   pop_count,
  input  logic                         group_start,
  input  logic [cdcs_pkg::CNT_W-1:0]   group_length,
  output logic                         strobe,
  output logic [cdcs_pkg::ST_W-1:0]    status,
  output logic [cdcs_pkg::DATA_W-1:0]  char_out,
  output logic [cdcs_pkg::CNT_W-1:0]   position,
  output logic [cdcs_pkg::CNT_W-1:0]   entry_count,
  output logic                         answer_flag,
  output logic                         last
);

  logic            q_full;
  logic            q_push;
  logic            q_valid;
  logic            q_pop;
  cdcs_pkg::item_t f_item;
  cdcs_pkg::item_t q_item;
  cdcs_pkg::res_t  res;

  cdcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .data_char    (data_char),
    .pop_count    (pop_count),
    .group_start  (group_start),
    .group_length (group_length),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (f_item)
  );

  cdcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .valid   (q_valid),
    .full    (q_full)
  );

  cdcs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (strobe),
    .res       (res)
  );

  assign status      = res.status;
  assign char_out    = res.char_out;
  assign position    = res.position;
  assign entry_count = res.entry_count;
  assign answer_flag = res.answer_flag;
  assign last        = res.last;

endmodule
